>>> hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_BKSP  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [1:0] ESC_IDLE    = 2'd0;
  localparam logic [1:0] ESC_SEEN    = 2'd1;
  localparam logic [1:0] ESC_NUMBER  = 2'd2;
  localparam logic [1:0] ESC_SWALLOW = 2'd3;

  localparam logic [1:0] MODE_DONE   = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_SCROLL = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_M       = 8'h6D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [3:0]  WHITE      = 4'd15;
  localparam logic [3:0]  BLACK      = 4'd0;
  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load_out;
    logic copy;
    logic blank;
    logic cnt_clr;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       copy_last;
    logic       blank_last;
    logic       out_free;
  } status_t;

  function automatic logic [3:0] ansi_to_vga(input logic [2:0] c);
    logic [3:0] v;
    case (c)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd4;
      3'd2:    v = 4'd2;
      3'd3:    v = 4'd14;
      3'd4:    v = 4'd1;
      3'd5:    v = 4'd5;
      3'd6:    v = 4'd3;
      default: v = 4'd15;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: accept, execute, read wait, scroll and clear
// sweeps, result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  tcw_pkg::status_t status_i,
  output tcw_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_BLANK  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0] state_q, state_d;
  logic       ready;

  assign ready     = (state_q == S_IDLE) || ((state_q == S_RESULT) && status_i.out_free);
  assign s_ready_o = ready;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.accept   = s_valid_i && ready;
    case (state_q)
      S_INIT: begin
        cmd_o.blank = 1'b1;
        if (status_i.blank_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (status_i.mode)
          tcw_pkg::MODE_READ: state_d = S_READ;
          tcw_pkg::MODE_SCROLL: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_COPY;
          end
          tcw_pkg::MODE_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_BLANK;
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_READ: begin
        state_d = S_RESULT;
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (status_i.copy_last) state_d = S_BLANK;
      end
      S_BLANK: begin
        cmd_o.blank = 1'b1;
        if (status_i.blank_last) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = s_valid_i ? S_EXEC : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, colors, escape parser, sweep counter, cell store and result
// register of the console.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcw_pkg::cmd_t                    cmd_i,
  output tcw_pkg::status_t                 status_o,
  input  logic [tcw_pkg::S_TDATA_W-1:0]    s_tdata_i,
  input  logic [tcw_pkg::S_TUSER_W-1:0]    s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  output logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata_o
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);

  logic [1:0]    req_q;
  logic [7:0]    ch_q;
  logic [10:0]   idx_q;

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [3:0]    fg_q, fg_d, bg_q, bg_d;
  logic [1:0]    esc_q, esc_d;
  logic [7:0]    num_q, num_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          rd_ok_q, rd_ok_d;

  logic          out_valid_q;
  logic [38:0]   out_q;

  logic [AW-1:0] pos;
  logic [31:0]   pos_w;
  logic [31:0]   row_w;
  logic          in_range;
  logic [15:0]   idx_ext;
  logic          emit, wr_en, last_row;
  logic [AW-1:0] wr_idx;
  logic [7:0]    wr_ch;
  logic [11:0]   num_next;
  logic          copy_last, blank_last;
  logic [1:0]    mode;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  assign pos_w    = 32'(row_q) * COLS + 32'(col_q);
  assign pos      = pos_w[AW-1:0];
  assign row_w    = 32'(row_q);
  assign idx_ext  = 16'(idx_q);
  assign in_range = idx_ext < 16'(CELLS);
  assign last_row = row_q == RW'(ROWS - 1);
  assign num_next = 12'(num_q) * 12'd10 + 12'(ch_q - tcw_pkg::CH_ZERO);

  assign copy_last  = cnt_q == AW'(CELLS - COLS);
  assign blank_last = cnt_q == AW'(CELLS - 1);

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    fg_d    = fg_q;
    bg_d    = bg_q;
    esc_d   = esc_q;
    num_d   = num_q;
    rd_ok_d = rd_ok_q;
    emit    = 1'b0;
    wr_en   = 1'b0;
    wr_idx  = pos;
    wr_ch   = ch_q;
    mode    = tcw_pkg::MODE_DONE;
    case (req_q)
      tcw_pkg::REQ_PUT: begin
        case (esc_q)
          tcw_pkg::ESC_IDLE: begin
            if (ch_q == tcw_pkg::CH_ESC) begin
              esc_d = tcw_pkg::ESC_SEEN;
              num_d = '0;
            end else begin
              emit = 1'b1;
            end
          end
          tcw_pkg::ESC_SWALLOW: begin
            if (ch_q == tcw_pkg::CH_M) esc_d = tcw_pkg::ESC_IDLE;
          end
          default: begin
            if ((esc_q == tcw_pkg::ESC_SEEN) && (ch_q == tcw_pkg::CH_BRACKET)) begin
              esc_d = tcw_pkg::ESC_NUMBER;
            end else if (ch_q inside {[tcw_pkg::CH_ZERO:tcw_pkg::CH_NINE]}) begin
              num_d = (num_next > 12'd255) ? 8'd255 : num_next[7:0];
              esc_d = tcw_pkg::ESC_NUMBER;
            end else begin
              if (num_q == 8'd0) begin
                fg_d = tcw_pkg::WHITE;
                bg_d = tcw_pkg::BLACK;
              end else if (num_q inside {[8'd30:8'd37]}) begin
                fg_d = tcw_pkg::ansi_to_vga(num_q[2:0] - 3'd6);
              end else if (num_q inside {[8'd40:8'd47]}) begin
                bg_d = tcw_pkg::ansi_to_vga(num_q[2:0]);
              end
              esc_d = (ch_q == tcw_pkg::CH_M) ? tcw_pkg::ESC_IDLE : tcw_pkg::ESC_SWALLOW;
            end
          end
        endcase
        if (emit) begin
          if ((ch_q == tcw_pkg::CH_NEWLINE) || (col_q == CW'(COLS - 1))) begin
            wr_en = ch_q != tcw_pkg::CH_NEWLINE;
            col_d = '0;
            if (last_row) begin
              mode = tcw_pkg::MODE_SCROLL;
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            wr_en = 1'b1;
            col_d = col_q + 1'b1;
          end
        end
      end
      tcw_pkg::REQ_BKSP: begin
        if (col_q != '0) begin
          col_d  = col_q - 1'b1;
          wr_en  = 1'b1;
          wr_idx = pos - 1'b1;
          wr_ch  = tcw_pkg::CH_SPACE;
        end
      end
      tcw_pkg::REQ_CLEAR: begin
        mode  = tcw_pkg::MODE_CLEAR;
        row_d = '0;
        col_d = '0;
        fg_d  = tcw_pkg::WHITE;
        bg_d  = tcw_pkg::BLACK;
      end
      default: begin
        mode = tcw_pkg::MODE_READ;
      end
    endcase
    rd_ok_d = (req_q == tcw_pkg::REQ_READ) && in_range;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.copy && !copy_last) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.blank) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_wdata = {bg_q, fg_q, wr_ch};
    ram_re    = 1'b0;
    ram_raddr = idx_ext[AW-1:0];
    if (cmd_i.copy) begin
      ram_re    = !copy_last;
      ram_raddr = cnt_q + AW'(COLS);
      ram_we    = cnt_q != '0;
      ram_waddr = cnt_q - 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd_i.blank) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q;
      ram_wdata = tcw_pkg::BLANK_CELL;
    end else if (cmd_i.exec) begin
      ram_we = wr_en;
      ram_re = rd_ok_d;
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= s_tuser_i;
      ch_q  <= s_tdata_i[7:0];
      idx_q <= s_tdata_i[18:8];
    end
    if (cmd_i.load_out) begin
      out_q[4:0]   <= row_w[4:0];
      out_q[11:5]  <= 7'(col_q);
      out_q[22:12] <= pos_w[10:0];
      out_q[30:23] <= rd_ok_q ? ram_rdata[7:0] : 8'd0;
      out_q[38:31] <= rd_ok_q ? ram_rdata[15:8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      fg_q        <= tcw_pkg::WHITE;
      bg_q        <= tcw_pkg::BLACK;
      esc_q       <= tcw_pkg::ESC_IDLE;
      num_q       <= '0;
      cnt_q       <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        row_q   <= row_d;
        col_q   <= col_d;
        fg_q    <= fg_d;
        bg_q    <= bg_d;
        esc_q   <= esc_d;
        num_q   <= num_d;
        rd_ok_q <= rd_ok_d;
      end
      cnt_q <= cnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.mode       = mode;
  assign status_o.copy_last  = copy_last;
  assign status_o.blank_last = blank_last;
  assign status_o.out_free   = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_q};

endmodule

>>> hdl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console with a ROWS x COLS cell store, cursor and ANSI color escapes.
// ----------------------------------------------------------------------------
// After reset the block blanks its cell store, one cell a cycle, before
// it takes the first beat. Every cell read, in range or not, passes
// through an extra read-wait state, since the store has a registered
// read port. A clear screen rewrites every cell through the single
// write port, and a scroll moves the store up by one row through that
// port and blanks the bottom row. Each input beat yields exactly one
// result beat.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // char_code[7:0], cell_index[18:8], zero pad
  input  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [tcw_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // cursor_row[4:0], cursor_col[11:5], cursor_pos[22:12],
  // read_char[30:23], read_attr[38:31], zero pad
  output logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tcw_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule
